[design/hetma_pkg.sv]
// ----------------------------------------------------------------------------
// Harmonic Et moment accumulator package
// Shared widths, word types and the saturating and rounding arithmetic used by
// the trigonometric front end, the harmonic cells and the result readout.
// ----------------------------------------------------------------------------
package hetma_pkg;

    // Number of harmonics kept per region; harmonic orders run 2 .. N+1.
    localparam int NUM_HARMONICS = 6;
    // Width of the azimuth code that addresses the angle table.
    localparam int PHI_BITS      = 12;
    localparam int QTR_BITS      = PHI_BITS - 2;

    localparam int ETA_W   = 10;
    localparam int PHIIN_W = 12;
    localparam int ET_W    = 24;
    localparam int THR_W   = 9;
    localparam int ACC_W   = 48;
    localparam int TRIG_W  = 16;
    localparam int PROD_W  = 2 * TRIG_W;
    localparam int PE_W    = ET_W + TRIG_W;
    localparam int HARM_W  = 4;
    localparam int HI_W    = (NUM_HARMONICS > 1) ? $clog2(NUM_HARMONICS) : 1;

    localparam logic [THR_W-1:0]  FWD_THR_RESET = THR_W'(320);
    localparam logic [HARM_W-1:0] HARM_BASE     = HARM_W'(2);

    // Region codes.
    localparam logic REGION_FULL = 1'b0;
    localparam logic REGION_FWD  = 1'b1;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef t_acc [1:0] t_pair;

    // Word handed from one harmonic cell to the next.
    typedef struct packed {
        logic                     v;
        logic                     last;
        logic                     fwd;
        logic signed [ET_W-1:0]   et;
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] pc;
        logic signed [TRIG_W-1:0] ps;
    } t_link;

    // End-of-event moments of one harmonic, both regions.
    typedef struct packed {
        t_pair cos_m;
        t_pair sin_m;
    } t_snap;

    // Signed add that saturates to the accumulator range.
    function automatic t_acc sat_add(input t_acc a, input t_acc b);
        logic signed [ACC_W:0] sum;
        t_acc res;
        sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            res = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            res = sum[ACC_W-1:0];
        end
        return res;
    endfunction

    // Round a Q3.30 sum of two products to Q1.15 (floor after adding a half) and clamp.
    function automatic logic signed [TRIG_W-1:0] rnd15(input logic signed [PROD_W:0] v);
        logic signed [PROD_W:0]    t;
        logic signed [PROD_W-15:0] q;
        logic signed [TRIG_W-1:0]  res;
        t = v + (PROD_W+1)'(16384);
        q = (PROD_W-14)'(t >>> 15);
        if (q > (PROD_W-14)'(32767)) begin
            res = TRIG_W'(32767);
        end else if (q < -(PROD_W-14)'(32767)) begin
            res = -TRIG_W'(32767);
        end else begin
            res = TRIG_W'(q);
        end
        return res;
    endfunction

endpackage

[design/hetma_trig.sv]
// ----------------------------------------------------------------------------
// Cosine and sine look-up
// Quarter-wave table of cos and sin in Q1.15, built at elaboration from a
// fixed-point Taylor series, read with a registered port, then unfolded to
// the full circle by quadrant and registered again.
// ----------------------------------------------------------------------------
module hetma_trig (
    input  logic                                  i_clk,
    input  logic [hetma_pkg::PHI_BITS-1:0]        i_phi,
    output logic signed [hetma_pkg::TRIG_W-1:0]   o_cos,
    output logic signed [hetma_pkg::TRIG_W-1:0]   o_sin
);
    import hetma_pkg::*;

    localparam int          ROM_DEPTH   = 1 << QTR_BITS;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [29:0] t_rom [ROM_DEPTH];
    typedef enum logic [1:0] {Q_FIRST, Q_SECOND, Q_THIRD, Q_FOURTH} t_quad;

    // Each entry holds cos in the upper half and sin in the lower half.
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic [63:0] sv;
        logic [63:0] cv;
        for (int r = 0; r < ROM_DEPTH; r++) begin
            x  = (64'(r) * HALF_PI_Q30) >> QTR_BITS;
            x2 = (x * x) >> 30;
            ts = Q30_ONE;
            ts = Q30_ONE - ((x2 * ts) >> 30) / 64'd110;
            ts = Q30_ONE - ((x2 * ts) >> 30) / 64'd72;
            ts = Q30_ONE - ((x2 * ts) >> 30) / 64'd42;
            ts = Q30_ONE - ((x2 * ts) >> 30) / 64'd20;
            ts = Q30_ONE - ((x2 * ts) >> 30) / 64'd6;
            tc = Q30_ONE;
            tc = Q30_ONE - ((x2 * tc) >> 30) / 64'd132;
            tc = Q30_ONE - ((x2 * tc) >> 30) / 64'd90;
            tc = Q30_ONE - ((x2 * tc) >> 30) / 64'd56;
            tc = Q30_ONE - ((x2 * tc) >> 30) / 64'd30;
            tc = Q30_ONE - ((x2 * tc) >> 30) / 64'd12;
            tc = Q30_ONE - ((x2 * tc) >> 30) / 64'd2;
            sv = (((x * ts) >> 30) + 64'd16384) >> 15;
            cv = (tc + 64'd16384) >> 15;
            if (sv > 64'd32767) begin
                sv = 64'd32767;
            end
            if (cv > 64'd32767) begin
                cv = 64'd32767;
            end
            rom[r] = {cv[14:0], sv[14:0]};
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [29:0]              r_rom_q;
    t_quad                    r_quad;
    logic signed [TRIG_W-1:0] w_cpos;
    logic signed [TRIG_W-1:0] w_spos;
    logic signed [TRIG_W-1:0] n_cos;
    logic signed [TRIG_W-1:0] n_sin;
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;

    // Table read.
    always_ff @(posedge i_clk) begin
        r_rom_q <= ROM[i_phi[QTR_BITS-1:0]];
        r_quad  <= t_quad'(i_phi[PHI_BITS-1 -: 2]);
    end

    assign w_cpos = {1'b0, r_rom_q[29:15]};
    assign w_spos = {1'b0, r_rom_q[14:0]};

    // Unfold the first-quadrant pair to the quadrant of the code.
    always_comb begin
        case (r_quad)
            Q_FIRST: begin
                n_cos = w_cpos;
                n_sin = w_spos;
            end
            Q_SECOND: begin
                n_cos = -w_spos;
                n_sin = w_cpos;
            end
            Q_THIRD: begin
                n_cos = -w_cpos;
                n_sin = -w_spos;
            end
            Q_FOURTH: begin
                n_cos = w_spos;
                n_sin = -w_cpos;
            end
            default: begin
                n_cos = w_cpos;
                n_sin = w_spos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cos <= n_cos;
        r_sin <= n_sin;
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

[design/hetma_cell.sv]
// ----------------------------------------------------------------------------
// Harmonic cell
// One cell per harmonic order. It turns the previous harmonic's cos and sin
// into its own by angle addition, hands them on to the next cell, and keeps
// the Et-weighted cos and sin sums of both regions. On the last word of an
// event it freezes its sums in a snapshot that rotates along the row during
// readout.
// ----------------------------------------------------------------------------
module hetma_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hetma_pkg::t_link  i_link,
    output hetma_pkg::t_link  o_link,
    input  logic              i_shift,
    input  hetma_pkg::t_snap  i_snap_next,
    output hetma_pkg::t_snap  o_snap
);
    import hetma_pkg::*;

    // First stage: the four angle-addition products.
    logic                     r_p1_v;
    logic                     r_p1_last;
    logic                     r_p1_fwd;
    logic signed [ET_W-1:0]   r_p1_et;
    logic signed [TRIG_W-1:0] r_p1_c;
    logic signed [TRIG_W-1:0] r_p1_s;
    logic signed [PROD_W-1:0] r_m_cc;
    logic signed [PROD_W-1:0] r_m_ss;
    logic signed [PROD_W-1:0] r_m_sc;
    logic signed [PROD_W-1:0] r_m_cs;

    // Second stage: this harmonic's cos and sin, also the word to the next cell.
    t_link                    r_p2;

    // Third stage: Et times cos and sin.
    logic                     r_p3_v;
    logic                     r_p3_last;
    logic                     r_p3_fwd;
    logic signed [PE_W-1:0]   r_pe_cos;
    logic signed [PE_W-1:0]   r_pe_sin;

    // Accumulators and snapshot.
    t_pair                    r_acc_cos;
    t_pair                    r_acc_sin;
    t_pair                    n_acc_cos;
    t_pair                    n_acc_sin;
    t_snap                    r_snap;
    t_acc                     w_upd_cos;
    t_acc                     w_upd_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else begin
            r_p1_v <= i_link.v;
        end
        r_p1_last <= i_link.last;
        r_p1_fwd  <= i_link.fwd;
        r_p1_et   <= i_link.et;
        r_p1_c    <= i_link.c;
        r_p1_s    <= i_link.s;
        r_m_cc    <= i_link.pc * i_link.c;
        r_m_ss    <= i_link.ps * i_link.s;
        r_m_sc    <= i_link.ps * i_link.c;
        r_m_cs    <= i_link.pc * i_link.s;
    end

    // Round the angle-addition sums to Q1.15; cos uses the previous cos and sin.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2.v <= 1'b0;
        end else begin
            r_p2.v <= r_p1_v;
        end
        r_p2.last <= r_p1_last;
        r_p2.fwd  <= r_p1_fwd;
        r_p2.et   <= r_p1_et;
        r_p2.c    <= r_p1_c;
        r_p2.s    <= r_p1_s;
        r_p2.pc   <= rnd15((PROD_W+1)'(r_m_cc) - (PROD_W+1)'(r_m_ss));
        r_p2.ps   <= rnd15((PROD_W+1)'(r_m_sc) + (PROD_W+1)'(r_m_cs));
    end

    assign o_link = r_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_v <= 1'b0;
        end else begin
            r_p3_v <= r_p2.v;
        end
        r_p3_last <= r_p2.last;
        r_p3_fwd  <= r_p2.fwd;
        r_pe_cos  <= r_p2.et * r_p2.pc;
        r_pe_sin  <= r_p2.et * r_p2.ps;
    end

    // Saturating update of the accumulator pair of the word's region.
    assign w_upd_cos = sat_add(r_acc_cos[r_p3_fwd], ACC_W'(r_pe_cos));
    assign w_upd_sin = sat_add(r_acc_sin[r_p3_fwd], ACC_W'(r_pe_sin));

    always_comb begin
        n_acc_cos = r_acc_cos;
        n_acc_sin = r_acc_sin;
        n_acc_cos[r_p3_fwd] = w_upd_cos;
        n_acc_sin[r_p3_fwd] = w_upd_sin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_cos <= '0;
            r_acc_sin <= '0;
        end else if (r_p3_v && r_p3_last) begin
            r_acc_cos <= '0;
            r_acc_sin <= '0;
        end else if (r_p3_v) begin
            r_acc_cos <= n_acc_cos;
            r_acc_sin <= n_acc_sin;
        end
    end

    // The snapshot takes the event's final sums, or rotates during readout.
    always_ff @(posedge i_clk) begin
        if (r_p3_v && r_p3_last) begin
            r_snap.cos_m <= n_acc_cos;
            r_snap.sin_m <= n_acc_sin;
        end else if (i_shift) begin
            r_snap <= i_snap_next;
        end
    end

    assign o_snap = r_snap;

endmodule

[design/hetma_readout.sv]
// ----------------------------------------------------------------------------
// Result readout
// Once the event's last word has left the final cell, sends one result word
// per region and harmonic from the head of the snapshot row, merging the
// forward sums into the full sums for region 0, and rotates the row after
// each word.
// ----------------------------------------------------------------------------
module hetma_readout (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_tail_last,
    input  hetma_pkg::t_snap                     i_snap,
    input  hetma_pkg::t_pair                     i_et_snap,
    input  logic                                 i_ready,
    output logic                                 o_valid,
    output logic                                 o_region,
    output logic [hetma_pkg::HARM_W-1:0]         o_harmonic,
    output logic signed [hetma_pkg::ACC_W-1:0]   o_et,
    output logic signed [hetma_pkg::ACC_W-1:0]   o_cos,
    output logic signed [hetma_pkg::ACC_W-1:0]   o_sin,
    output logic                                 o_last,
    output logic                                 o_shift,
    output logic                                 o_done
);
    import hetma_pkg::*;

    logic              r_tail_d;
    logic              r_active;
    logic              r_rg;
    logic [HI_W-1:0]   r_hi;
    logic              r_valid;
    logic              r_region;
    logic [HARM_W-1:0] r_harmonic;
    t_acc              r_et;
    t_acc              r_cos;
    t_acc              r_sin;
    logic              r_last;
    logic              w_load;
    logic              w_hi_end;

    assign w_load   = r_active && (!r_valid || i_ready);
    assign w_hi_end = (r_hi == HI_W'(NUM_HARMONICS - 1));

    // Sequencing: start from the registered tail flag r_tail_d so the final
    // cell's snapshot has landed, then step through harmonics and regions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_d <= 1'b0;
            r_active <= 1'b0;
            r_rg     <= REGION_FULL;
            r_hi     <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_tail_d <= i_tail_last;
            if (r_tail_d) begin
                r_active <= 1'b1;
            end else if (w_load && w_hi_end && (r_rg == REGION_FWD)) begin
                r_active <= 1'b0;
            end
            if (w_load) begin
                if (w_hi_end) begin
                    r_hi <= '0;
                    r_rg <= ~r_rg;
                end else begin
                    r_hi <= r_hi + HI_W'(1);
                end
            end
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_region   <= r_rg;
            r_harmonic <= HARM_W'(r_hi) + HARM_BASE;
            r_last     <= w_hi_end && (r_rg == REGION_FWD);
            if (r_rg == REGION_FULL) begin
                r_et  <= sat_add(i_et_snap[0], i_et_snap[1]);
                r_cos <= sat_add(i_snap.cos_m[0], i_snap.cos_m[1]);
                r_sin <= sat_add(i_snap.sin_m[0], i_snap.sin_m[1]);
            end else begin
                r_et  <= i_et_snap[1];
                r_cos <= i_snap.cos_m[1];
                r_sin <= i_snap.sin_m[1];
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_region   = r_region;
    assign o_harmonic = r_harmonic;
    assign o_et       = r_et;
    assign o_cos      = r_cos;
    assign o_sin      = r_sin;
    assign o_last     = r_last;
    assign o_shift    = w_load;
    assign o_done     = r_valid && i_ready && r_last;

endmodule

[design/harmonic_et_moment_accumulator.sv]
// ----------------------------------------------------------------------------
// Harmonic Et moment accumulator
// Sums calorimeter cell Et and Et-weighted cos(n*phi), sin(n*phi) for the
// central and forward regions over an event, and on the event's last cell
// reports the full-calorimeter and forward moments for each harmonic order.
//
//   channel   direction  handshake                     word
//   cell      in         i_cell_valid / o_cell_ready   eta, phi, Et, last flag
//   result    out        o_res_valid / i_res_ready     region, n, Et, cos, sin, last
//   config    in         i_cfg_we                      forward eta threshold
//
// One cell word is taken every clock while the block is not reading out.
// After a cell word marked last, input is held off until all 2*NUM_HARMONICS
// result words of that event have been taken; the first result follows the
// last cell through the input stages, the row of harmonic cells at two
// stages each, and three readout start-up stages. Results then leave one per
// clock unless i_res_ready is low, and input reopens in the cycle after the
// final result word is taken. Reset is synchronous and clears all sums; the
// threshold returns to 320.
// ----------------------------------------------------------------------------
module harmonic_et_moment_accumulator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [hetma_pkg::THR_W-1:0]          i_cfg_wdata,
    input  logic                                 i_cell_valid,
    output logic                                 o_cell_ready,
    input  logic signed [hetma_pkg::ETA_W-1:0]   i_cell_eta,
    input  logic [hetma_pkg::PHIIN_W-1:0]        i_cell_phi,
    input  logic signed [hetma_pkg::ET_W-1:0]    i_cell_et,
    input  logic                                 i_last_cell,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    output logic                                 o_region,
    output logic [hetma_pkg::HARM_W-1:0]         o_harmonic,
    output logic signed [hetma_pkg::ACC_W-1:0]   o_region_et_sum,
    output logic signed [hetma_pkg::ACC_W-1:0]   o_cos_moment,
    output logic signed [hetma_pkg::ACC_W-1:0]   o_sin_moment,
    output logic                                 o_last_result
);
    import hetma_pkg::*;

    logic [THR_W-1:0]         r_fwd_thr;
    logic                     r_busy;
    logic                     w_accept;
    logic                     w_done;

    logic                     r_s0_v;
    logic signed [ETA_W-1:0]  r_s0_eta;
    logic [PHIIN_W-1:0]       r_s0_phi;
    logic signed [ET_W-1:0]   r_s0_et;
    logic                     r_s0_last;
    logic [ETA_W-1:0]         w_aeta;

    logic                     r_s1_v;
    logic                     r_s1_fwd;
    logic signed [ET_W-1:0]   r_s1_et;
    logic                     r_s1_last;

    logic                     r_s2_v;
    logic                     r_s2_fwd;
    logic signed [ET_W-1:0]   r_s2_et;
    logic                     r_s2_last;

    logic signed [TRIG_W-1:0] w_cos;
    logic signed [TRIG_W-1:0] w_sin;

    t_pair                    r_et_acc;
    t_pair                    n_et_acc;
    t_pair                    r_et_snap;

    t_link                    w_link [NUM_HARMONICS+1];
    t_snap                    w_snap [NUM_HARMONICS];
    logic                     w_shift;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_thr <= FWD_THR_RESET;
        end else if (i_cfg_we) begin
            r_fwd_thr <= i_cfg_wdata;
        end
    end

    // Input is held off from a last cell until its results have all gone.
    assign o_cell_ready = !r_busy;
    assign w_accept     = i_cell_valid && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept && i_last_cell) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else begin
            r_s0_v <= w_accept;
        end
        if (w_accept) begin
            r_s0_eta  <= i_cell_eta;
            r_s0_phi  <= i_cell_phi;
            r_s0_et   <= i_cell_et;
            r_s0_last <= i_last_cell;
        end
    end

    // Region decision on abs(eta); abs of the most negative code is 512.
    assign w_aeta = r_s0_eta[ETA_W-1] ? ETA_W'(-r_s0_eta) : ETA_W'(r_s0_eta);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
        end
        r_s1_fwd  <= (w_aeta > ETA_W'(r_fwd_thr)) ? REGION_FWD : REGION_FULL;
        r_s1_et   <= r_s0_et;
        r_s1_last <= r_s0_last;
        r_s2_fwd  <= r_s1_fwd;
        r_s2_et   <= r_s1_et;
        r_s2_last <= r_s1_last;
    end

    hetma_trig u_trig (
        .i_clk (i_clk),
        .i_phi (PHI_BITS'(r_s0_phi)),
        .o_cos (w_cos),
        .o_sin (w_sin)
    );

    // Region Et sums, frozen and cleared on the last cell.
    always_comb begin
        n_et_acc = r_et_acc;
        n_et_acc[r_s1_fwd] = sat_add(r_et_acc[r_s1_fwd], ACC_W'(r_s1_et));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_et_acc <= '0;
        end else if (r_s1_v && r_s1_last) begin
            r_et_acc <= '0;
        end else if (r_s1_v) begin
            r_et_acc <= n_et_acc;
        end
        if (r_s1_v && r_s1_last) begin
            r_et_snap <= n_et_acc;
        end
    end

    // The first cell builds harmonic two from the angle with itself.
    always_comb begin
        w_link[0].v    = r_s2_v;
        w_link[0].last = r_s2_last;
        w_link[0].fwd  = r_s2_fwd;
        w_link[0].et   = r_s2_et;
        w_link[0].c    = w_cos;
        w_link[0].s    = w_sin;
        w_link[0].pc   = w_cos;
        w_link[0].ps   = w_sin;
    end

    // Row of harmonic cells; snapshots rotate towards cell zero on readout.
    for (genvar g = 0; g < NUM_HARMONICS; g++) begin : g_cell
        hetma_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_link      (w_link[g]),
            .o_link      (w_link[g+1]),
            .i_shift     (w_shift),
            .i_snap_next (w_snap[(g + 1) % NUM_HARMONICS]),
            .o_snap      (w_snap[g])
        );
    end

    hetma_readout u_readout (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tail_last (w_link[NUM_HARMONICS].v && w_link[NUM_HARMONICS].last),
        .i_snap      (w_snap[0]),
        .i_et_snap   (r_et_snap),
        .i_ready     (i_res_ready),
        .o_valid     (o_res_valid),
        .o_region    (o_region),
        .o_harmonic  (o_harmonic),
        .o_et        (o_region_et_sum),
        .o_cos       (o_cos_moment),
        .o_sin       (o_sin_moment),
        .o_last      (o_last_result),
        .o_shift     (w_shift),
        .o_done      (w_done)
    );

endmodule

[design/hetma_checker.sv]
// ----------------------------------------------------------------------------
// Harmonic Et moment accumulator port checker
// Watches the top-level ports for the event flow control and the shape of the
// result run, and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module hetma_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cell_valid,
    input  logic                                 o_cell_ready,
    input  logic                                 i_last_cell,
    input  logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    input  logic                                 o_region,
    input  logic [hetma_pkg::HARM_W-1:0]         o_harmonic,
    input  logic signed [hetma_pkg::ACC_W-1:0]   o_cos_moment,
    input  logic                                 o_last_result
);
    import hetma_pkg::*;

    // A last cell closes the input until its results have been read out.
    a_hold_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cell_valid && o_cell_ready && i_last_cell) |=> !o_cell_ready)
        else $error("cell word accepted directly after a last cell");

    // Taking the final result word reopens the input.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && o_last_result) |=> o_cell_ready)
        else $error("input not reopened after the final result word");

    // The final word of a run is the forward region's highest harmonic.
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_last_result) |->
            (o_region == REGION_FWD &&
             o_harmonic == HARM_W'(NUM_HARMONICS) + HARM_BASE - HARM_W'(1)))
        else $error("final result word has the wrong region or harmonic");

    // No result word is shown while cells are still being taken in.
    a_no_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !o_cell_ready)
        else $error("result word shown while the input is open");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=>
            (o_res_valid && $stable(o_cos_moment) && $stable(o_harmonic)))
        else $error("stalled result word changed");

endmodule

bind harmonic_et_moment_accumulator hetma_checker u_hetma_checker (.*);
